// File: rtl/sorted_priority_queue_unit_macros.svh
// Assertion macros shared by the queue's modules.
// Each macro expects a signal named clk and a signal named rst in scope.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define SPQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("queue check failed");

// Check a property on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("queue check failed");

`else

`define SPQ_ASSERT(name, prop)

`define SPQ_ASSERT_ALWAYS(name, prop)

`endif

`endif

// File: rtl/spq_pkg.sv
package spq_pkg;

  // Queue geometry and field widths.
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PRIO_BITS   = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_BITS    = 5;

  // Request kinds as they arrive on the input word.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_SERVE  = 2'd3
  } req_kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Input word.
  typedef struct packed {
    req_kind_t              req_type;
    logic [ID_BITS-1:0]     entry_id;
    logic [PRIO_BITS-1:0]   prio_value;
  } req_word_t;

  // Output word.
  typedef struct packed {
    status_t                status;
    logic [ID_BITS-1:0]     served_id;
    logic [PRIO_BITS-1:0]   served_prio;
    logic [OCC_BITS-1:0]    occupancy;
  } rsp_word_t;

  // Operations the datapath applies to the slot row.
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } dp_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;
    dp_op_t op;
    logic   save_rm;
    logic   use_rm;
    logic   emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_kind_t kind;
  } dp_stat_t;

endpackage

// File: rtl/sorted_priority_queue_unit.sv
// Sorted priority queue: a row of slot registers kept in descending priority order.
// The request word is registered on acceptance; the result word is registered when the
// controller executes the request, once the result register is free. An update removes
// and then re-inserts. A new request is accepted only when the controller is idle, after
// its accept, execute and (for an update) insert steps over the single slot row.
// Reset (synchronous, active high) empties the queue and clears all handshakes.
module sorted_priority_queue_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  spq_pkg::req_word_t req_word,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output spq_pkg::rsp_word_t rsp_word
);
  import spq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing of each request.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Slot row, compares and the result register.
  spq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_word (req_word),
    .cmd      (cmd),
    .stat     (stat),
    .rsp_word (rsp_word)
  );

endmodule

// File: rtl/spq_ctrl.sv
`include "sorted_priority_queue_unit_macros.svh"

module spq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  spq_pkg::dp_stat_t stat,
  output spq_pkg::dp_cmd_t  cmd
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_INS  = 2'd2
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // Command decode.
  always_comb begin
    cmd        = '0;
    cmd.op     = OP_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          case (stat.kind)
            REQ_INSERT: begin
              cmd.op     = OP_INSERT;
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
            end
            REQ_REMOVE: begin
              cmd.op     = OP_REMOVE;
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
            end
            REQ_UPDATE: begin
              // Remove first; the insert follows in the insert state, once the result register is free.
              cmd.op      = OP_REMOVE;
              cmd.save_rm = 1'b1;
              state_next  = S_INS;
            end
            REQ_SERVE: begin
              cmd.op     = OP_POP;
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_INS: begin
        if (out_free) begin
          cmd.op     = OP_INSERT;
          cmd.use_rm = 1'b1;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `SPQ_ASSERT(a_emit_only_when_free, cmd.emit |-> out_free)
  `SPQ_ASSERT(a_update_goes_to_insert,
              (state == S_EXEC && stat.kind == REQ_UPDATE && out_free) |=> state == S_INS)
  `SPQ_ASSERT(a_result_after_work, $rose(rsp_valid) |-> $past(state) != S_IDLE)

endmodule

// File: rtl/spq_datapath.sv
`include "sorted_priority_queue_unit_macros.svh"

module spq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::req_word_t req_word,
  input  spq_pkg::dp_cmd_t   cmd,
  output spq_pkg::dp_stat_t  stat,
  output spq_pkg::rsp_word_t rsp_word
);
  import spq_pkg::*;

  // Slot row, held in queue order.
  logic [ID_BITS-1:0]   ids   [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] prios [QUEUE_DEPTH];
  logic [CNT_W-1:0]     count;

  req_word_t req_q;
  status_t   rm_st;

  logic [QUEUE_DEPTH-1:0] in_use;
  logic [QUEUE_DEPTH-1:0] hit;
  logic [QUEUE_DEPTH-1:0] ge;
  logic [QUEUE_DEPTH-1:0] past_hit;
  logic [QUEUE_DEPTH-1:0] prev_ge;
  logic                   found;
  logic                   empty;
  logic                   full;

  logic [ID_BITS-1:0]   up_ids     [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] up_prios   [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   dn_ids     [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] dn_prios   [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   ids_next   [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] prios_next [QUEUE_DEPTH];
  logic [CNT_W-1:0]     count_next;
  status_t              st_now;
  logic [ID_BITS-1:0]   sid;
  logic [PRIO_BITS-1:0] sprio;

  assign stat.kind = req_q.req_type;
  assign empty     = (count == '0);
  assign full      = (count == CNT_W'(QUEUE_DEPTH));

  // Per-slot compares against the held request.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      in_use[i] = (CNT_W'(i) < count);
      hit[i]    = in_use[i] && (ids[i] == req_q.entry_id);
      ge[i]     = in_use[i] && (prios[i] >= req_q.prio_value);
    end
  end

  // Slots at or behind the first matching id, and the slots that follow an
  // entry of equal or higher priority.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      past_hit[i] = hit[i];
      for (int j = 0; j < i; j++) begin
        past_hit[i] = past_hit[i] | hit[j];
      end
    end
    prev_ge[0] = 1'b0;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      prev_ge[i] = ge[i-1];
    end
  end

  assign found = |hit;

  // Neighbour taps for shifting towards the tail and towards the head.
  always_comb begin
    up_ids[0]   = req_q.entry_id;
    up_prios[0] = req_q.prio_value;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      up_ids[i]   = ids[i-1];
      up_prios[i] = prios[i-1];
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      dn_ids[i]   = ids[i+1];
      dn_prios[i] = prios[i+1];
    end
    dn_ids[QUEUE_DEPTH-1]   = ids[QUEUE_DEPTH-1];
    dn_prios[QUEUE_DEPTH-1] = prios[QUEUE_DEPTH-1];
  end

  // Next slot contents, fill count and result fields.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids_next[i]   = ids[i];
      prios_next[i] = prios[i];
    end
    count_next = count;
    st_now     = ST_OK;
    sid        = '0;
    sprio      = '0;
    case (cmd.op)
      OP_INSERT: begin
        if (full) begin
          st_now = ST_FULL;
        end else begin
          st_now = cmd.use_rm ? rm_st : ST_OK;
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (!ge[i]) begin
              ids_next[i]   = prev_ge[i] ? req_q.entry_id   : up_ids[i];
              prios_next[i] = prev_ge[i] ? req_q.prio_value : up_prios[i];
            end
          end
          count_next = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          st_now = ST_EMPTY;
        end else if (!found) begin
          st_now = ST_NOT_FOUND;
        end else begin
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (past_hit[i]) begin
              ids_next[i]   = dn_ids[i];
              prios_next[i] = dn_prios[i];
            end
          end
          count_next = count - 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          st_now = ST_EMPTY;
        end else begin
          sid   = ids[0];
          sprio = prios[0];
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ids_next[i]   = dn_ids[i];
            prios_next[i] = dn_prios[i];
          end
          count_next = count - 1'b1;
        end
      end
      default: begin
        st_now = ST_OK;
      end
    endcase
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Slot row, held request, saved remove status and the result word.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids[i]   <= ids_next[i];
      prios[i] <= prios_next[i];
    end
    if (cmd.load) begin
      req_q <= req_word;
    end
    if (cmd.save_rm) begin
      rm_st <= st_now;
    end
    if (cmd.emit) begin
      rsp_word.status      <= st_now;
      rsp_word.served_id   <= sid;
      rsp_word.served_prio <= sprio;
      rsp_word.occupancy   <= OCC_BITS'(count_next);
    end
  end

  `SPQ_ASSERT(a_count_bound, count <= CNT_W'(QUEUE_DEPTH))
  `SPQ_ASSERT(a_insert_grows,
              (cmd.op == OP_INSERT && !full) |=> count == $past(count) + 1'b1)
  `SPQ_ASSERT(a_pop_shrinks,
              (cmd.op == OP_POP && !empty) |=> count == $past(count) - 1'b1)

endmodule
